// ===== hw/rtl/bmp565_pkg.sv =====
`default_nettype none

package bmp565_pkg;

   localparam int HEADER_BYTES    = 54;
   localparam int ROW_STRIDE_LOG2 = 9;
   localparam int WIDTH_LSB       = 18;
   localparam int HEIGHT_LSB      = 22;
   localparam int FIELD_BYTES     = 4;

   localparam int COUNT_W  = 6;
   localparam int DIM_W    = 32;
   localparam int OFFSET_W = 32;
   localparam int PLACE_W  = 10;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_OFFSET = 2'd0,
      CSR_Y_OFFSET = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bmp_to_rgb565_framebuffer_writer.sv =====
`default_nettype none

// Parses a 24-bit BMP file streamed one byte per request and emits one RGB565 pixel per
// three data bytes, with a frame-buffer halfword offset of
// ((row + y_offset + 1) << 9) + (col + x_offset + 1), rows from height down to 1. The
// block takes one byte every cycle with no stalls of its own. A byte goes into an input
// register, the parse logic works on it in the next cycle and a pixel is then written
// into the result register, from which it is presented. While a pixel waits unread in
// the result register, bytes that make no pixel still pass through; the next third byte
// waits in the input register and holds the request side off until the result is taken.
// Bytes are ignored after reset, after the last pixel, or after a header with a
// non-positive width or height, until a request with new_file set starts a new parse.
module bmp_to_rgb565_framebuffer_writer
   import bmp565_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_new_file,

   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [OFFSET_W-1:0]  rsp_pixel_offset,
   output      logic [15:0]          rsp_rgb565,

   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PLACE_W-1:0]   csr_write_data
);

   // configuration
   logic [PLACE_W-1:0] x_offset_ff, y_offset_ff;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_new_file_ff;

   // parse state
   logic [COUNT_W-1:0] header_count_ff, header_count_in;
   logic [DIM_W-1:0]   image_width_ff, image_width_in;
   logic [DIM_W-1:0]   image_height_ff, image_height_in;
   logic [DIM_W-1:0]   row_counter_ff, row_counter_in;
   logic [DIM_W-1:0]   column_counter_ff, column_counter_in;
   phase_type          byte_phase_ff, byte_phase_in;
   logic [4:0]         first_color_ff, first_color_in;
   logic [5:0]         second_color_ff, second_color_in;
   logic               image_done_ff, image_done_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [15:0]         rsp_color_ff;

   // effective state after a new_file restart
   logic [COUNT_W-1:0] eff_count;
   logic [DIM_W-1:0]   eff_width, eff_height, eff_row, eff_col;
   phase_type          eff_phase;
   logic [4:0]         eff_first;
   logic [5:0]         eff_second;
   logic               eff_done;

   logic [COUNT_W-1:0] width_lane, height_lane;
   logic [DIM_W-1:0]   col_next, row_next;
   logic [DIM_W-1:0]   row_term, col_term;
   logic [OFFSET_W-1:0] pixel_offset;
   logic [15:0]        pixel_rgb;
   logic               produce, out_free, s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= '0;
         y_offset_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_X_OFFSET: x_offset_ff <= csr_write_data;
            CSR_Y_OFFSET: y_offset_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_done   = s1_new_file_ff ? 1'b0 : image_done_ff;
      eff_count  = s1_new_file_ff ? '0 : header_count_ff;
      eff_width  = s1_new_file_ff ? '0 : image_width_ff;
      eff_height = s1_new_file_ff ? '0 : image_height_ff;
      eff_row    = s1_new_file_ff ? '0 : row_counter_ff;
      eff_col    = s1_new_file_ff ? '0 : column_counter_ff;
      eff_phase  = s1_new_file_ff ? PHASE_FIRST : byte_phase_ff;
      eff_first  = s1_new_file_ff ? '0 : first_color_ff;
      eff_second = s1_new_file_ff ? '0 : second_color_ff;
   end

   assign width_lane  = eff_count - COUNT_W'(WIDTH_LSB);
   assign height_lane = eff_count - COUNT_W'(HEIGHT_LSB);
   assign col_next    = eff_col + DIM_W'(1);
   assign row_next    = eff_row - DIM_W'(1);

   assign row_term     = eff_row + DIM_W'(y_offset_ff) + DIM_W'(1);
   assign col_term     = eff_col + DIM_W'(x_offset_ff) + DIM_W'(1);
   assign pixel_offset = OFFSET_W'(row_term << ROW_STRIDE_LOG2) + OFFSET_W'(col_term);
   assign pixel_rgb    = {s1_byte_ff[7:3], eff_second, eff_first};

   always_comb begin
      header_count_in   = eff_count;
      image_width_in    = eff_width;
      image_height_in   = eff_height;
      row_counter_in    = eff_row;
      column_counter_in = eff_col;
      byte_phase_in     = eff_phase;
      first_color_in    = eff_first;
      second_color_in   = eff_second;
      image_done_in     = eff_done;
      produce           = 1'b0;

      if (!eff_done) begin
         if (eff_count < COUNT_W'(HEADER_BYTES)) begin
            if (eff_count >= COUNT_W'(WIDTH_LSB) &&
                eff_count < COUNT_W'(WIDTH_LSB + FIELD_BYTES)) begin
               image_width_in[{width_lane[1:0], 3'b000} +: 8] = s1_byte_ff;
            end else if (eff_count >= COUNT_W'(HEIGHT_LSB) &&
                         eff_count < COUNT_W'(HEIGHT_LSB + FIELD_BYTES)) begin
               image_height_in[{height_lane[1:0], 3'b000} +: 8] = s1_byte_ff;
            end
            header_count_in = eff_count + COUNT_W'(1);
            if (eff_count == COUNT_W'(HEADER_BYTES - 1)) begin
               row_counter_in    = eff_height;
               column_counter_in = '0;
               byte_phase_in     = PHASE_FIRST;
               // signed test: zero or negative dimension means nothing to draw
               if (eff_width[DIM_W-1] || eff_width == '0 ||
                   eff_height[DIM_W-1] || eff_height == '0) begin
                  image_done_in = 1'b1;
               end
            end
         end else begin
            unique case (eff_phase)
               PHASE_FIRST: begin
                  first_color_in = s1_byte_ff[7:3];
                  byte_phase_in  = PHASE_SECOND;
               end
               PHASE_SECOND: begin
                  second_color_in = s1_byte_ff[7:2];
                  byte_phase_in   = PHASE_THIRD;
               end
               PHASE_THIRD: begin
                  produce       = 1'b1;
                  byte_phase_in = PHASE_FIRST;
                  if (col_next == eff_width) begin
                     column_counter_in = '0;
                     row_counter_in    = row_next;
                     if (row_next == '0) begin
                        image_done_in = 1'b1;
                     end
                  end else begin
                     column_counter_in = col_next;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!produce || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff     <= req_data_byte;
         s1_new_file_ff <= req_new_file;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff   <= '0;
         image_width_ff    <= '0;
         image_height_ff   <= '0;
         row_counter_ff    <= '0;
         column_counter_ff <= '0;
         byte_phase_ff     <= PHASE_FIRST;
         first_color_ff    <= '0;
         second_color_ff   <= '0;
         image_done_ff     <= 1'b1;
      end else if (s1_advance) begin
         header_count_ff   <= header_count_in;
         image_width_ff    <= image_width_in;
         image_height_ff   <= image_height_in;
         row_counter_ff    <= row_counter_in;
         column_counter_ff <= column_counter_in;
         byte_phase_ff     <= byte_phase_in;
         first_color_ff    <= first_color_in;
         second_color_ff   <= second_color_in;
         image_done_ff     <= image_done_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_advance && produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && produce) begin
         rsp_offset_ff <= pixel_offset;
         rsp_color_ff  <= pixel_rgb;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_offset = rsp_offset_ff;
   assign rsp_rgb565       = rsp_color_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= COUNT_W'(HEADER_BYTES))
      else $error("header count ran past the header");

   a_rows_left: assert property (@(posedge clock) disable iff (reset)
      (!image_done_ff && header_count_ff == COUNT_W'(HEADER_BYTES))
      |-> (row_counter_ff != '0 && column_counter_ff < image_width_ff))
      else $error("pixel position outside the image while drawing");

   a_pixel_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("pixel appeared without a buffered request");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && produce && !out_free) |-> !req_ready)
      else $error("request taken while a pixel could not be stored");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bmp565_pkg::*;

   localparam int ITEM_TARGET   = 850;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int IDLE_PERCENT  = 29;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [15:0]         color;
   } pixel_type;

   // Tracks the BMP parse, predicts every pixel and checks what comes out.
   class pixel_scoreboard;
      logic [PLACE_W-1:0] x_place;
      logic [PLACE_W-1:0] y_place;
      logic [COUNT_W-1:0] header_count;
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [DIM_W-1:0]   row;
      logic [DIM_W-1:0]   col;
      phase_type          phase;
      logic [7:0]         blue_byte;
      logic [7:0]         green_byte;
      bit                 image_done;
      pixel_type          expected_pixels[$];
      int                 bytes_taken;
      int                 pixels_checked;
      int                 errors;

      function new();
         x_place        = '0;
         y_place        = '0;
         header_count   = '0;
         image_width    = '0;
         image_height   = '0;
         row            = '0;
         col            = '0;
         phase          = PHASE_FIRST;
         blue_byte      = '0;
         green_byte     = '0;
         image_done     = 1'b1;
         bytes_taken    = 0;
         pixels_checked = 0;
         errors         = 0;
      endfunction

      function void set_placement(logic [CSR_IDX_W-1:0] idx, logic [PLACE_W-1:0] value);
         case (idx)
            CSR_X_OFFSET: x_place = value;
            CSR_Y_OFFSET: y_place = value;
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] b, logic new_file);
         pixel_type        px;
         logic [DIM_W-1:0] row_pos;
         if (new_file) begin
            header_count = '0;
            image_width  = '0;
            image_height = '0;
            row          = '0;
            col          = '0;
            phase        = PHASE_FIRST;
            blue_byte    = '0;
            green_byte   = '0;
            image_done   = 1'b0;
         end
         if (image_done)
            return;
         bytes_taken++;

         if (header_count < HEADER_BYTES) begin
            if (header_count >= WIDTH_LSB && header_count < WIDTH_LSB + FIELD_BYTES)
               image_width[8*(header_count-WIDTH_LSB) +: 8] = b;
            else if (header_count >= HEIGHT_LSB && header_count < HEIGHT_LSB + FIELD_BYTES)
               image_height[8*(header_count-HEIGHT_LSB) +: 8] = b;
            header_count++;
            if (header_count == HEADER_BYTES) begin
               row   = image_height;
               col   = '0;
               phase = PHASE_FIRST;
               // signed test: zero or negative dimensions end the image here
               if ($signed(image_width) <= 0 || $signed(image_height) <= 0)
                  image_done = 1'b1;
            end
            return;
         end

         case (phase)
            PHASE_FIRST: begin
               blue_byte = b;
               phase     = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               green_byte = b;
               phase      = PHASE_THIRD;
            end
            default: begin
               phase     = PHASE_FIRST;
               px.color  = {b[7:3], green_byte[7:2], blue_byte[7:3]};
               row_pos   = row + DIM_W'(y_place) + 32'd1;
               px.offset = (row_pos << ROW_STRIDE_LOG2) + col + OFFSET_W'(x_place) + 32'd1;
               expected_pixels.push_back(px);
               col++;
               if (col == image_width) begin
                  col = '0;
                  row--;
                  if (row == '0)
                     image_done = 1'b1;
               end
            end
         endcase
      endfunction

      function void check_pixel(logic [OFFSET_W-1:0] offset, logic [15:0] color);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel, offset %h color %h", $time, offset, color);
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (offset !== want.offset) begin
            errors++;
            $display("%0t: pixel_offset mismatch, expected %h, actual %h",
                     $time, want.offset, offset);
         end
         if (color !== want.color) begin
            errors++;
            $display("%0t: rgb565 mismatch, expected %h, actual %h",
                     $time, want.color, color);
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_byte    = '0;
   logic                 req_new_file     = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [OFFSET_W-1:0]  rsp_pixel_offset;
   logic [15:0]          rsp_rgb565;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [PLACE_W-1:0]   csr_write_data   = '0;

   pixel_scoreboard pixels = new();

   bit steady   = 1'b0;
   bit hold_rsp = 1'b0;
   int files_sent;
   int settings_used;
   int holds_done;
   int quiet_cycles;

   bmp_to_rgb565_framebuffer_writer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_new_file     (req_new_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_rgb565       (rsp_rgb565),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            pixels.set_placement(csr_index, csr_write_data);
         if (req_valid && req_ready)
            pixels.take_byte(req_data_byte, req_new_file);
         if (rsp_valid && rsp_ready)
            pixels.check_pixel(rsp_pixel_offset, rsp_rgb565);
      end
   end

   // result side: random stalls, one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_rsp = 1'b0;
         holds_done++;
      end
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic new_file);
      @(negedge clock);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_new_file  <= new_file;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_bytes(input int n);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // header with the given dimensions; a short len leaves the header cut off
   task automatic send_header(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input int len = HEADER_BYTES);
      logic [7:0] b;
      files_sent++;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(255));
         if (i >= WIDTH_LSB && i < WIDTH_LSB + FIELD_BYTES)
            b = w[8*(i-WIDTH_LSB) +: 8];
         else if (i >= HEIGHT_LSB && i < HEIGHT_LSB + FIELD_BYTES)
            b = h[8*(i-HEIGHT_LSB) +: 8];
         send_byte(b, i == 0);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixels.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_placement(input logic [PLACE_W-1:0] x, input logic [PLACE_W-1:0] y);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_X_OFFSET;
      csr_write_data   <= x;
      @(negedge clock);
      csr_index        <= CSR_Y_OFFSET;
      csr_write_data   <= y;
      @(negedge clock);
      csr_index        <= $urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI;
      csr_write_data   <= PLACE_W'($urandom_range(1023));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int               kind;
      int               w;
      int               h;
      logic [DIM_W-1:0] bad_w;
      logic [DIM_W-1:0] bad_h;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle after reset: ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // 2x1 image, all-ones then all-zeros color, then ignored tail
      send_header(2, 1);
      repeat (3) send_byte(8'hFF, 1'b0);
      repeat (3) send_byte(8'h00, 1'b0);
      send_bytes(2);

      program_placement(10'h3FF, 10'h3FF);
      send_header(2, 2);
      send_bytes(13);

      // non-positive dimensions
      send_header(0, 3);
      send_bytes(3);
      send_header(32'hFFFF_FFFF, 2);
      send_bytes(3);
      send_header(3, 32'h8000_0000);
      send_bytes(3);

      // huge image: offsets wrap; restart mid-pixel and mid-header
      send_header(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_bytes(13);
      send_header(4, 4, 20);

      program_placement(10'h000, 10'h3FF);
      send_header(3, 2);
      send_bytes(18);
      program_placement(10'h3FF, 10'h000);

      while (pixels.bytes_taken < ITEM_TARGET) begin
         steady = (files_sent >= 14 && files_sent < 18);
         if (files_sent % 3 == 0) begin
            case ($urandom_range(3))
               0: program_placement(10'h000, 10'h000);
               1: program_placement(10'h3FF, 10'h3FF);
               default: program_placement(PLACE_W'($urandom_range(1023)),
                                          PLACE_W'($urandom_range(1023)));
            endcase
         end
         if (holds_done == 0 && !hold_rsp && files_sent >= 10) begin
            // result side stops while the request side keeps offering
            hold_rsp = 1'b1;
            send_header(40, 2);
            send_bytes(40 * 2 * 3);
            continue;
         end
         kind = $urandom_range(99);
         w    = $urandom_range(1, 8);
         h    = $urandom_range(1, 4);
         if (kind < 70) begin
            if ($urandom_range(19) == 0)
               w = $urandom_range(20, 40);
            send_header(w, h);
            send_bytes(w * h * 3);
            if ($urandom_range(99) < 30)
               send_bytes($urandom_range(1, 5));
         end else if (kind < 80) begin
            send_header(w, h);
            send_bytes($urandom_range(0, w * h * 3 - 1));
         end else if (kind < 87) begin
            case ($urandom_range(3))
               0: bad_w = 32'd0;
               1: bad_w = 32'h8000_0000;
               2: bad_w = 32'hFFFF_FFFF;
               default: bad_w = 32'h8000_0000 | $urandom;
            endcase
            bad_h = w;
            if ($urandom_range(1))
               {bad_w, bad_h} = {bad_h, bad_w};
            send_header(bad_w, bad_h);
            send_bytes($urandom_range(1, 6));
         end else if (kind < 93) begin
            send_header(w, h, $urandom_range(1, HEADER_BYTES - 1));
         end else begin
            send_bytes($urandom_range(1, 8));
         end
      end

      steady = 1'b0;
      drain();

      $display("Sent %0d files, %0d bytes parsed, %0d pixels checked, %0d placement settings.",
               files_sent, pixels.bytes_taken, pixels.pixels_checked, settings_used);
      $display("Covered bad dimensions, wrapped offsets, restarts mid-file and a long output hold.");
      if (pixels.errors == 0 && pixels.expected_pixels.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
